// File: sv/pip_pkg.sv
// shared types and constants for the point-in-polygon crossing test
package pip_pkg;

  localparam int COORD_BITS  = 16;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS   = 2 * DIFF_BITS;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = QPTR_BITS + 1;

  localparam int RES_DEPTH   = 4;
  localparam int RPTR_BITS   = $clog2(RES_DEPTH);
  localparam int RCNT_BITS   = RPTR_BITS + 1;

  typedef struct packed {
    logic                        first;
    logic                        last;
    logic                        straddle;
    logic                        dy_pos;
    logic signed [DIFF_BITS-1:0] ex;
    logic signed [DIFF_BITS-1:0] ey;
    logic signed [DIFF_BITS-1:0] dx;
    logic signed [DIFF_BITS-1:0] dy;
  } edge_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [RCNT_BITS-1:0] res_count;
    logic                 s1_valid;
    logic                 parity;
  } bk_stat_t;

endpackage

// File: sv/point_in_polygon_test_top.sv
// Crossing-number point-in-polygon test, one polygon vertex per word. Each
// word carries the query point and one vertex; first_vertex clears the
// parity, every other word closes an edge from the previous vertex, and a
// word with last_vertex yields one inside_res word. The polygon is not closed
// automatically: repeat the first vertex as the last one. A word is taken
// every cycle while full is low, and full is high during reset; a result can
// be popped once its word has passed the edge queue write, the edge queue
// read into the product register and the result queue write. The back end
// takes one word a cycle while the four-entry result queue has a slot for
// it; with the result queue held full by withholding pop, the edge queue
// fills and full rises.
module point_in_polygon_test_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [pip_pkg::COORD_BITS-1:0] query_x,
  input  logic signed [pip_pkg::COORD_BITS-1:0] query_y,
  input  logic signed [pip_pkg::COORD_BITS-1:0] vertex_x,
  input  logic signed [pip_pkg::COORD_BITS-1:0] vertex_y,
  input  logic                                  first_vertex,
  input  logic                                  last_vertex,
  output logic                                  empty,
  input  logic                                  pop,
  output logic                                  inside_res
);

  logic              q_wr;
  logic              q_rd;
  pip_pkg::edge_t    q_wdata;
  pip_pkg::edge_t    q_rdata;
  pip_pkg::q_stat_t  q_stat;
  pip_pkg::bk_stat_t bk_stat;

  assign full = q_stat.full || rst;

  pip_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .q_full       (q_stat.full),
    .query_x      (query_x),
    .query_y      (query_y),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .first_vertex (first_vertex),
    .last_vertex  (last_vertex),
    .q_wr         (q_wr),
    .q_word       (q_wdata)
  );

  pip_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  pip_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_stat.empty),
    .q_word     (q_rdata),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .inside_res (inside_res),
    .stat       (bk_stat)
  );

  a_res_no_overflow : assert property (@(posedge clk) disable iff (rst)
    (bk_stat.res_count + pip_pkg::RCNT_BITS'(bk_stat.s1_valid)) <=
    pip_pkg::RCNT_BITS'(pip_pkg::RES_DEPTH))
    else $error("result queue over-committed");

  a_empty_match : assert property (@(posedge clk) disable iff (rst)
    empty == (bk_stat.res_count == '0))
    else $error("empty disagrees with result count");

  a_queue_fill : assert property (@(posedge clk) disable iff (rst)
    (push && !full && q_stat.empty) |=> !q_stat.empty)
    else $error("accepted word lost from edge queue");

  a_first_clears : assert property (@(posedge clk) disable iff (rst)
    (q_rd && q_rdata.first) |=> ##1 !bk_stat.parity)
    else $error("first vertex did not clear parity");

endmodule

// File: sv/pip_front.sv
// front end: keeps the previous vertex and classifies each edge
module pip_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  input  logic                                  q_full,
  input  logic signed [pip_pkg::COORD_BITS-1:0] query_x,
  input  logic signed [pip_pkg::COORD_BITS-1:0] query_y,
  input  logic signed [pip_pkg::COORD_BITS-1:0] vertex_x,
  input  logic signed [pip_pkg::COORD_BITS-1:0] vertex_y,
  input  logic                                  first_vertex,
  input  logic                                  last_vertex,
  output logic                                  q_wr,
  output pip_pkg::edge_t                        q_word
);

  logic signed [pip_pkg::COORD_BITS-1:0] prev_x;
  logic signed [pip_pkg::COORD_BITS-1:0] prev_y;

  assign q_wr = push && !q_full;

  always_comb begin
    q_word          = '0;
    q_word.first    = first_vertex;
    q_word.last     = last_vertex;
    q_word.straddle = ((prev_y <= query_y) && (vertex_y > query_y)) ||
                      ((prev_y > query_y) && (vertex_y <= query_y));
    q_word.dy_pos   = vertex_y > prev_y;
    q_word.ex = pip_pkg::DIFF_BITS'(query_x) - pip_pkg::DIFF_BITS'(prev_x);
    q_word.ey = pip_pkg::DIFF_BITS'(query_y) - pip_pkg::DIFF_BITS'(prev_y);
    q_word.dx = pip_pkg::DIFF_BITS'(vertex_x) - pip_pkg::DIFF_BITS'(prev_x);
    q_word.dy = pip_pkg::DIFF_BITS'(vertex_y) - pip_pkg::DIFF_BITS'(prev_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
    end else if (q_wr) begin
      prev_x <= vertex_x;
      prev_y <= vertex_y;
    end
  end

endmodule

// File: sv/pip_queue.sv
// short queue of classified edges between front and back
module pip_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  pip_pkg::edge_t   wdata,
  input  logic             rd,
  output pip_pkg::edge_t   rdata,
  output pip_pkg::q_stat_t stat
);

  pip_pkg::edge_t                mem [pip_pkg::QUEUE_DEPTH];
  logic [pip_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [pip_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [pip_pkg::QCNT_BITS-1:0] count;

  assign rdata      = mem[rd_ptr];
  assign stat.full  = count == pip_pkg::QCNT_BITS'(pip_pkg::QUEUE_DEPTH);
  assign stat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/pip_back.sv
// back end: cross products, parity update and result queue
module pip_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  pip_pkg::edge_t    q_word,
  output logic              q_rd,
  input  logic              pop,
  output logic              empty,
  output logic              inside_res,
  output pip_pkg::bk_stat_t stat
);

  logic                                  s1_valid;
  logic                                  s1_first;
  logic                                  s1_last;
  logic                                  s1_straddle;
  logic                                  s1_dy_pos;
  logic signed [pip_pkg::PROD_BITS-1:0]  s1_p1;
  logic signed [pip_pkg::PROD_BITS-1:0]  s1_p2;
  logic                                  parity;
  logic                                  parity_next;
  logic                                  left;

  logic                                  res_mem [pip_pkg::RES_DEPTH];
  logic [pip_pkg::RPTR_BITS-1:0]         res_wr_ptr;
  logic [pip_pkg::RPTR_BITS-1:0]         res_rd_ptr;
  logic [pip_pkg::RCNT_BITS-1:0]         res_count;
  logic                                  res_wr;
  logic                                  res_rd;

  // reserve a result slot for the word in flight
  assign q_rd = !q_empty &&
                ((res_count + pip_pkg::RCNT_BITS'(s1_valid)) <
                 pip_pkg::RCNT_BITS'(pip_pkg::RES_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= q_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      s1_first    <= q_word.first;
      s1_last     <= q_word.last;
      s1_straddle <= q_word.straddle;
      s1_dy_pos   <= q_word.dy_pos;
      s1_p1 <= pip_pkg::PROD_BITS'(q_word.ex) * pip_pkg::PROD_BITS'(q_word.dy);
      s1_p2 <= pip_pkg::PROD_BITS'(q_word.ey) * pip_pkg::PROD_BITS'(q_word.dx);
    end
  end

  assign left = s1_dy_pos ? (s1_p1 < s1_p2) : (s1_p2 < s1_p1);

  always_comb begin
    parity_next = parity;
    if (s1_valid) begin
      if (s1_first) begin
        parity_next = 1'b0;
      end else if (s1_straddle && left) begin
        parity_next = !parity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= 1'b0;
    end else begin
      parity <= parity_next;
    end
  end

  assign res_wr     = s1_valid && s1_last;
  assign res_rd     = pop && !empty;
  assign empty      = res_count == '0;
  assign inside_res = res_mem[res_rd_ptr];

  always_ff @(posedge clk) begin
    if (res_wr) begin
      res_mem[res_wr_ptr] <= parity_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_ptr <= '0;
      res_rd_ptr <= '0;
      res_count  <= '0;
    end else begin
      if (res_wr) begin
        res_wr_ptr <= res_wr_ptr + 1'b1;
      end
      if (res_rd) begin
        res_rd_ptr <= res_rd_ptr + 1'b1;
      end
      case ({res_wr, res_rd})
        2'b10:   res_count <= res_count + 1'b1;
        2'b01:   res_count <= res_count - 1'b1;
        default: res_count <= res_count;
      endcase
    end
  end

  assign stat.res_count = res_count;
  assign stat.s1_valid  = s1_valid;
  assign stat.parity    = parity;

endmodule
